>>> rtl/dwmes_pkg.sv
// Shared constants and helpers for the dual-window moving event sum.
// Used by every module of the block; no dependencies of its own.
package dwmes_pkg;

   // Port widths fixed by the result format
   localparam int SECOND_W = 32;
   localparam int MINUTE_W = 38;
   localparam int HOUR_W   = 44;

   // Default window lengths and count width
   localparam int DEF_LONG_WINDOW  = 3600;
   localparam int DEF_SHORT_WINDOW = 60;
   localparam int DEF_COUNT_BITS   = 32;

   // Stored count width: the masked count never exceeds the input port width
   function automatic int count_width(input int bits);
      int w;
      w = (bits < SECOND_W) ? bits : SECOND_W;
      return w;
   endfunction

   // Slot pointer width for a store of the given depth
   function automatic int slot_width(input int depth);
      int w;
      w = (depth > 1) ? $clog2(depth) : 1;
      return w;
   endfunction

endpackage

>>> rtl/dwmes_front.sv
// Front end: accepts count beats, masks them and tags each with its store slots.
// Depends on dwmes_pkg.
module dwmes_front #(
   parameter int LONG_WINDOW  = dwmes_pkg::DEF_LONG_WINDOW,
   parameter int SHORT_WINDOW = dwmes_pkg::DEF_SHORT_WINDOW,
   parameter int COUNT_BITS   = dwmes_pkg::DEF_COUNT_BITS,
   parameter int ENTRY_W      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dwmes_pkg::SECOND_W-1:0] req_second_count,
   input  logic                          q_full,
   input  logic                          clearing,
   output logic                          q_push,
   output logic [ENTRY_W-1:0]            q_wdata
);
   import dwmes_pkg::*;

   localparam int CountW    = count_width(COUNT_BITS);
   localparam int SlotW     = slot_width(LONG_WINDOW);
   localparam int Back      = SHORT_WINDOW % LONG_WINDOW;
   localparam int ShortInit = (LONG_WINDOW - Back) % LONG_WINDOW;
   localparam int LastSlot  = LONG_WINDOW - 1;

   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [SlotW-1:0]  short_ff, short_in;
   logic [CountW-1:0] count;

   // Hold off while the store is being cleared or the queue has no room
   assign req_stall = q_full | clearing;
   assign q_push    = req_valid & ~req_stall;

   // Mask to the configured count width
   assign count   = req_second_count[CountW-1:0];
   assign q_wdata = {count, slot_ff, short_ff};

   // Both pointers step together and wrap at the store depth
   always_comb begin
      slot_in  = slot_ff;
      short_in = short_ff;
      if (q_push) begin
         slot_in  = (slot_ff == SlotW'(LastSlot)) ? '0 : slot_ff + 1'b1;
         short_in = (short_ff == SlotW'(LastSlot)) ? '0 : short_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         short_ff <= SlotW'(ShortInit);
      end else begin
         slot_ff  <= slot_in;
         short_ff <= short_in;
      end
   end

endmodule

>>> rtl/dwmes_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on dwmes_pkg for nothing but house conventions.
module dwmes_queue #(
   parameter int ENTRY_W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [ENTRY_W-1:0] wdata,
   input  logic               pop,
   output logic [ENTRY_W-1:0] rdata,
   output logic               not_empty,
   output logic               full
);
   import dwmes_pkg::*;

   logic [ENTRY_W-1:0] ent_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;

   assign rdata     = ent_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push & ~pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop & ~push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/dwmes_back.sv
// Back end: count store, clearing pass, window sums and the result register.
// Depends on dwmes_pkg.
module dwmes_back #(
   parameter int LONG_WINDOW  = dwmes_pkg::DEF_LONG_WINDOW,
   parameter int COUNT_BITS   = dwmes_pkg::DEF_COUNT_BITS,
   parameter int ENTRY_W      = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_not_empty,
   input  logic [ENTRY_W-1:0]             q_rdata,
   output logic                           q_pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dwmes_pkg::SECOND_W-1:0] rsp_last_second,
   output logic [dwmes_pkg::MINUTE_W-1:0] rsp_last_minute,
   output logic [dwmes_pkg::HOUR_W-1:0]   rsp_last_hour
);
   import dwmes_pkg::*;

   localparam int CountW   = count_width(COUNT_BITS);
   localparam int SlotW    = slot_width(LONG_WINDOW);
   localparam int LastSlot = LONG_WINDOW - 1;

   logic [CountW-1:0] mem [LONG_WINDOW];

   logic [CountW-1:0] head_count;
   logic [SlotW-1:0]  head_slot, head_short;

   logic              clr_ff, clr_in;
   logic [SlotW-1:0]  clr_addr_ff, clr_addr_in;

   logic              b_vld_ff, b_vld_in;
   logic [CountW-1:0] b_count_ff;
   logic [SlotW-1:0]  b_slot_ff;
   logic [CountW-1:0] rd_long_ff, rd_short_ff;
   logic              byp_short_ff;
   logic [CountW-1:0] byp_data_ff;

   logic              rsp_vld_ff, rsp_vld_in;
   logic [SECOND_W-1:0] sec_ff;
   logic [MINUTE_W-1:0] minute_sum_ff, minute_sum_in;
   logic [HOUR_W-1:0]   hour_sum_ff, hour_sum_in;

   logic              out_free, b_fire;
   logic              we;
   logic [SlotW-1:0]  wa;
   logic [CountW-1:0] wd;
   logic [CountW-1:0] leave_short;

   assign {head_count, head_slot, head_short} = q_rdata;

   // Pipeline control: result register frees up, B stage retires, head pops
   assign out_free = ~rsp_vld_ff | ~rsp_stall;
   assign b_fire   = b_vld_ff & out_free;
   assign q_pop    = q_not_empty & ~clr_ff & (~b_vld_ff | out_free);
   assign clearing = clr_ff;

   // Clearing pass: one slot per cycle after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SlotW'(LastSlot)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Store write port: zeros while clearing, else the retiring count
   assign we = clr_ff | b_fire;
   assign wa = clr_ff ? clr_addr_ff : b_slot_ff;
   assign wd = clr_ff ? '0 : b_count_ff;

   // Store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (q_pop) begin
         rd_long_ff  <= mem[head_slot];
         rd_short_ff <= mem[head_short];
      end
   end

   // B stage payload; the short read can hit the slot being written this cycle
   // (one-second short window). The long read never can: it trails by a whole store.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_count_ff   <= head_count;
         b_slot_ff    <= head_slot;
         byp_short_ff <= b_fire & (b_slot_ff == head_short);
         byp_data_ff  <= b_count_ff;
      end
   end

   assign leave_short = byp_short_ff ? byp_data_ff : rd_short_ff;

   // Window sums, wrapping at their widths
   always_comb begin
      b_vld_in      = b_vld_ff;
      rsp_vld_in    = rsp_vld_ff;
      minute_sum_in = minute_sum_ff;
      hour_sum_in   = hour_sum_ff;
      if (q_pop) begin
         b_vld_in = 1'b1;
      end else if (b_fire) begin
         b_vld_in = 1'b0;
      end
      if (b_fire) begin
         rsp_vld_in    = 1'b1;
         minute_sum_in = minute_sum_ff + MINUTE_W'(b_count_ff) - MINUTE_W'(leave_short);
         hour_sum_in   = hour_sum_ff + HOUR_W'(b_count_ff) - HOUR_W'(rd_long_ff);
      end else if (~rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff      <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         minute_sum_ff <= '0;
         hour_sum_ff   <= '0;
      end else begin
         b_vld_ff      <= b_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         minute_sum_ff <= minute_sum_in;
         hour_sum_ff   <= hour_sum_in;
      end
   end

   // Latest count for the result beat
   always_ff @(posedge clock) begin
      if (b_fire) begin
         sec_ff <= SECOND_W'(b_count_ff);
      end
   end

   // The sum registers double as the result fields
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_last_second = sec_ff;
   assign rsp_last_minute = minute_sum_ff;
   assign rsp_last_hour   = hour_sum_ff;

endmodule

>>> rtl/dual_window_moving_event_sum.sv
// Top level of the dual-window moving event sum: front end, queue, back end.
// Depends on dwmes_pkg, dwmes_front, dwmes_queue and dwmes_back.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_second_count (32)
//   rsp      out        rsp_valid / rsp_stall  rsp_last_second (32), rsp_last_minute (38),
//                                              rsp_last_hour (44)
//
// Sustained rate is one beat per cycle while rsp_stall stays low and no clearing pass
// runs. A result follows its request beat through the queue entry, the store reads in
// the B stage and the sum update into the result register. The store has one write
// port and two read ports, which sets that rate. After reset a clearing pass writes
// zeros to every store slot, with req_stall held high. A stalled result holds; the
// two-entry queue keeps taking beats until it fills, then req_stall rises.
module dual_window_moving_event_sum #(
   parameter int LONG_WINDOW  = dwmes_pkg::DEF_LONG_WINDOW,
   parameter int SHORT_WINDOW = dwmes_pkg::DEF_SHORT_WINDOW,
   parameter int COUNT_BITS   = dwmes_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dwmes_pkg::SECOND_W-1:0] req_second_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dwmes_pkg::SECOND_W-1:0] rsp_last_second,
   output logic [dwmes_pkg::MINUTE_W-1:0] rsp_last_minute,
   output logic [dwmes_pkg::HOUR_W-1:0]   rsp_last_hour
);
   import dwmes_pkg::*;

   localparam int EntryW = count_width(COUNT_BITS) + 2 * slot_width(LONG_WINDOW);

   logic              q_push, q_pop, q_full, q_not_empty, clearing;
   logic [EntryW-1:0] q_wdata, q_rdata;

   dwmes_front #(
      .LONG_WINDOW  (LONG_WINDOW),
      .SHORT_WINDOW (SHORT_WINDOW),
      .COUNT_BITS   (COUNT_BITS),
      .ENTRY_W      (EntryW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_second_count (req_second_count),
      .q_full           (q_full),
      .clearing         (clearing),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   dwmes_queue #(
      .ENTRY_W (EntryW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dwmes_back #(
      .LONG_WINDOW (LONG_WINDOW),
      .COUNT_BITS  (COUNT_BITS),
      .ENTRY_W     (EntryW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_second (rsp_last_second),
      .rsp_last_minute (rsp_last_minute),
      .rsp_last_hour   (rsp_last_hour)
   );

endmodule

>>> bench/dwmes_checker.sv
// Checker for the dual-window moving event sum: follows both channels, keeps its own
// per-second history with minute and hour totals, and compares every result beat.
// Depends on dwmes_pkg for port widths and default window lengths.
module dwmes_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [dwmes_pkg::SECOND_W-1:0] req_second_count,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [dwmes_pkg::SECOND_W-1:0] rsp_last_second,
   input  logic [dwmes_pkg::MINUTE_W-1:0] rsp_last_minute,
   input  logic [dwmes_pkg::HOUR_W-1:0]   rsp_last_hour,
   output int                             mismatches,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOUR_LEN   = dwmes_pkg::DEF_LONG_WINDOW;
   localparam int MINUTE_LEN = dwmes_pkg::DEF_SHORT_WINDOW;
   localparam int CNT_BITS   = dwmes_pkg::DEF_COUNT_BITS;
   localparam logic [dwmes_pkg::SECOND_W-1:0] CNT_MASK =
      (CNT_BITS >= dwmes_pkg::SECOND_W) ? '1 : ((1 << CNT_BITS) - 1);

   typedef struct packed {
      logic [dwmes_pkg::SECOND_W-1:0] second;
      logic [dwmes_pkg::MINUTE_W-1:0] minute;
      logic [dwmes_pkg::HOUR_W-1:0]   hour;
   } window_totals_type;

   // Predicted history of per-second counts and the two running totals
   logic [dwmes_pkg::SECOND_W-1:0] count_history [HOUR_LEN];
   int                             oldest_slot;
   logic [dwmes_pkg::MINUTE_W-1:0] minute_total;
   logic [dwmes_pkg::HOUR_W-1:0]   hour_total;

   window_totals_type totals_due [$];
   window_totals_type want;

   // Fold one second into both windows; returns the totals the block must report
   function automatic window_totals_type roll_windows(
      input logic [dwmes_pkg::SECOND_W-1:0] raw);
      logic [dwmes_pkg::SECOND_W-1:0] n;
      logic [dwmes_pkg::SECOND_W-1:0] drop_hour;
      logic [dwmes_pkg::SECOND_W-1:0] drop_minute;
      int                             minute_slot;
      window_totals_type              t;
      n           = raw & CNT_MASK;
      minute_slot = (oldest_slot + HOUR_LEN - (MINUTE_LEN % HOUR_LEN)) % HOUR_LEN;
      drop_hour   = count_history[oldest_slot];
      drop_minute = count_history[minute_slot];
      // totals wrap at their own widths
      hour_total   = hour_total + dwmes_pkg::HOUR_W'(n) - dwmes_pkg::HOUR_W'(drop_hour);
      minute_total = minute_total + dwmes_pkg::MINUTE_W'(n)
                     - dwmes_pkg::MINUTE_W'(drop_minute);
      count_history[oldest_slot] = n;
      oldest_slot = (oldest_slot + 1) % HOUR_LEN;
      t.second = n;
      t.minute = minute_total;
      t.hour   = hour_total;
      return t;
   endfunction

   // Predict on each request beat, compare on each result beat
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOUR_LEN; i++) count_history[i] = '0;
         oldest_slot  = 0;
         minute_total = '0;
         hour_total   = '0;
         totals_due.delete();
         mismatches   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            totals_due.push_back(roll_windows(req_second_count));
         end
         if (rsp_valid && !rsp_stall) begin
            if (totals_due.size() == 0) begin
               $error("result beat with nothing expected: second %0d minute %0d hour %0d",
                      rsp_last_second, rsp_last_minute, rsp_last_hour);
               mismatches++;
            end else begin
               want = totals_due.pop_front();
               if (rsp_last_second !== want.second) begin
                  $error("last_second: expected %0d, got %0d", want.second, rsp_last_second);
                  mismatches++;
               end
               if (rsp_last_minute !== want.minute) begin
                  $error("last_minute: expected %0d, got %0d", want.minute, rsp_last_minute);
                  mismatches++;
               end
               if (rsp_last_hour !== want.hour) begin
                  $error("last_hour: expected %0d, got %0d", want.hour, rsp_last_hour);
                  mismatches++;
               end
            end
         end
      end
      pending = totals_due.size();
   end

endmodule

>>> bench/tb_top.sv
// Top of the dual-window moving event sum bench: clock, reset, request stimulus,
// result-side stall and the final verdict. Depends on dwmes_pkg, the block and dwmes_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Beats per random phase; with the directed beats at least 1010 beats in all,
   // enough for many full minute windows and their leaving entries.
   localparam int PHASE_BEATS = 330;
   localparam int DRAIN_CYCLES = 8;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [dwmes_pkg::SECOND_W-1:0] req_second_count = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [dwmes_pkg::SECOND_W-1:0] rsp_last_second;
   logic [dwmes_pkg::MINUTE_W-1:0] rsp_last_minute;
   logic [dwmes_pkg::HOUR_W-1:0]   rsp_last_hour;
   int                             mismatches;
   int                             pending;
   int                             send_idle_pct = 0;
   int                             rcv_idle_pct = 0;

   dual_window_moving_event_sum uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_second_count (req_second_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_last_second  (rsp_last_second),
      .rsp_last_minute  (rsp_last_minute),
      .rsp_last_hour    (rsp_last_hour)
   );

   dwmes_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_second_count (req_second_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_last_second  (rsp_last_second),
      .rsp_last_minute  (rsp_last_minute),
      .rsp_last_hour    (rsp_last_hour),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always #2 clock = ~clock;

   // Result side stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   // One request beat; entered and left just after a rising edge.
   // Stall is sampled at the falling edge, when it is settled.
   task automatic send_count(input logic [dwmes_pkg::SECOND_W-1:0] value);
      logic stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_second_count <= value;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   // Hold the request side off until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Count values biased toward the edges of the field
   function automatic logic [dwmes_pkg::SECOND_W-1:0] random_count();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return dwmes_pkg::SECOND_W'($urandom_range(15));
         3: return dwmes_pkg::SECOND_W'(1) << $urandom_range(dwmes_pkg::SECOND_W - 1);
         4: return ~(dwmes_pkg::SECOND_W'(1) << $urandom_range(dwmes_pkg::SECOND_W - 1));
         default: return dwmes_pkg::SECOND_W'($urandom);
      endcase
   endfunction

   // Run limit
   initial begin
      #2_000_000;
      $display("dual_window_moving_event_sum: mismatch");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      logic [dwmes_pkg::SECOND_W-1:0] edge_counts [20];
      logic [dwmes_pkg::SECOND_W-1:0] run_value;
      int                             sent;
      int                             run_len;

      edge_counts = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                      32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0002, 32'h0001_0000,
                      32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                      32'h0000_0000, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0000_0003};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and the warm-up where every sum is the running total
      foreach (edge_counts[i]) send_count(edge_counts[i]);

      for (int phase = 0; phase < 3; phase++) begin
         // settings change only with nothing in flight
         wait_drained();
         case (phase)
            0: begin
               send_idle_pct = 19;
               rcv_idle_pct  = 50;
            end
            1: begin
               send_idle_pct = 50;
               rcv_idle_pct  = 19;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if ($urandom_range(19) == 0) begin
               // a run of one value; one longer than the minute window fills it edge to edge
               run_len   = $urandom_range(1, 90);
               run_value = ($urandom_range(1) == 0) ? '1 : '0;
               repeat (run_len) send_count(run_value);
               sent += run_len;
            end else begin
               send_count(random_count());
               sent++;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("dual_window_moving_event_sum: match");
      end else begin
         $display("dual_window_moving_event_sum: mismatch");
      end
      $finish;
   end

endmodule
